[sv/crld_pkg.sv]
package crld_pkg;

   localparam int ROWS       = 64;
   localparam int COLS       = 64;
   localparam int DEPTH      = ROWS * COLS;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COORD_W    = 6;
   localparam int CHAR_W     = 8;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h2A;  // '*'
   localparam logic [CHAR_W-1:0] CH_CROSS = 8'h2B;  // '+'
   localparam logic [CHAR_W-1:0] CH_HORIZ = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] CH_VERT  = 8'h7C;  // '|'
   localparam logic [CHAR_W-1:0] CH_RISE  = 8'h2F;  // '/'
   localparam logic [CHAR_W-1:0] CH_FALL  = 8'h5C;  // '\'

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_HORIZ = 3'd0,
      ST_VERT  = 3'd1,
      ST_RISE  = 3'd2,
      ST_FALL  = 3'd3,
      ST_BENT  = 3'd4,
      ST_READ  = 3'd5
   } status_type;

   // One classified request: start cell, step directions and cell count minus one.
   typedef struct packed {
      logic                is_read;
      status_type          status;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic                row_move;
      logic                row_dec;
      logic                col_move;
      logic [COORD_W-1:0]  len;
   } cmd_type;

endpackage

[sv/crld_front.sv]
module crld_front (
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_op,
   input  logic [crld_pkg::COORD_W-1:0]  req_start_row,
   input  logic [crld_pkg::COORD_W-1:0]  req_start_col,
   input  logic [crld_pkg::COORD_W-1:0]  req_end_row,
   input  logic [crld_pkg::COORD_W-1:0]  req_end_col,
   input  logic                          q_full,
   input  logic                          clearing,
   output logic                          q_push,
   output crld_pkg::cmd_type             q_cmd
);
   import crld_pkg::*;

   logic [COORD_W-1:0] dr;
   logic [COORD_W-1:0] dc;
   logic               rises;

   assign req_full = q_full | clearing;
   assign q_push   = req_push & ~req_full;

   assign dr    = (req_start_row > req_end_row) ? req_start_row - req_end_row
                                                : req_end_row - req_start_row;
   assign dc    = (req_start_col > req_end_col) ? req_start_col - req_end_col
                                                : req_end_col - req_start_col;
   assign rises = (req_end_row > req_start_row) != (req_end_col > req_start_col);

   always_comb begin
      q_cmd          = '0;
      q_cmd.status   = ST_BENT;
      if (req_op == OP_READ) begin
         q_cmd.is_read = 1'b1;
         q_cmd.status  = ST_READ;
         q_cmd.row     = req_start_row;
         q_cmd.col     = req_start_col;
      end else if (req_start_row == req_end_row) begin
         q_cmd.status   = ST_HORIZ;
         q_cmd.row      = req_start_row;
         q_cmd.col      = (req_start_col < req_end_col) ? req_start_col : req_end_col;
         q_cmd.col_move = 1'b1;
         q_cmd.len      = dc;
      end else if (req_start_col == req_end_col) begin
         q_cmd.status   = ST_VERT;
         q_cmd.row      = (req_start_row < req_end_row) ? req_start_row : req_end_row;
         q_cmd.col      = req_start_col;
         q_cmd.row_move = 1'b1;
         q_cmd.len      = dr;
      end else if (dr == dc && rises) begin
         // start at the lower endpoint (larger row), walk up and right
         q_cmd.status   = ST_RISE;
         q_cmd.row      = (req_end_row > req_start_row) ? req_end_row : req_start_row;
         q_cmd.col      = (req_end_row > req_start_row) ? req_end_col : req_start_col;
         q_cmd.row_move = 1'b1;
         q_cmd.row_dec  = 1'b1;
         q_cmd.col_move = 1'b1;
         q_cmd.len      = dr;
      end else if (dr == dc) begin
         // start at the upper endpoint (smaller row), walk down and right
         q_cmd.status   = ST_FALL;
         q_cmd.row      = (req_end_row < req_start_row) ? req_end_row : req_start_row;
         q_cmd.col      = (req_end_row < req_start_row) ? req_end_col : req_start_col;
         q_cmd.row_move = 1'b1;
         q_cmd.col_move = 1'b1;
         q_cmd.len      = dr;
      end
   end

endmodule

[sv/crld_cmd_queue.sv]
module crld_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crld_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output crld_pkg::cmd_type  pop_cmd,
   output logic               empty
);
   import crld_pkg::*;

   cmd_type                entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/crld_back.sv]
module crld_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  crld_pkg::cmd_type            q_cmd,
   output logic                         q_pop,
   output logic                         clearing,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [2:0]                   rsp_status,
   output logic [crld_pkg::CHAR_W-1:0]  rsp_cell_char
);
   import crld_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_WALK  = 4'b0100,
      S_RDATA = 4'b1000
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
      cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS)) + ADDR_W'(c);
   endfunction

   function automatic logic [CHAR_W-1:0] mark_of(input status_type s);
      case (s)
         ST_HORIZ: mark_of = CH_HORIZ;
         ST_VERT:  mark_of = CH_VERT;
         ST_RISE:  mark_of = CH_RISE;
         ST_FALL:  mark_of = CH_FALL;
         default:  mark_of = CH_CROSS;
      endcase
   endfunction

   logic [CHAR_W-1:0]   raster_mem [DEPTH];

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic [COORD_W-1:0]  col_ff, col_in;
   logic [COORD_W-1:0]  cnt_ff, cnt_in;
   logic                row_move_ff, row_move_in;
   logic                row_dec_ff, row_dec_in;
   logic                col_move_ff, col_move_in;
   logic [CHAR_W-1:0]   mark_ff, mark_in;
   logic                rd_ok_ff, rd_ok_in;
   logic                b_valid_ff, b_valid_in;
   logic [ADDR_W-1:0]   b_addr_ff, b_addr_in;
   logic [CHAR_W-1:0]   b_mark_ff, b_mark_in;
   logic                fwd_hit_ff;
   logic [CHAR_W-1:0]   fwd_data_ff;
   logic [CHAR_W-1:0]   rd_data_ff;
   logic                out_valid_ff, out_valid_in;
   logic [2:0]          out_status_ff, out_status_in;
   logic [CHAR_W-1:0]   out_char_ff, out_char_in;

   logic                out_free;
   logic                post;
   logic                walk_ok;
   logic [ADDR_W-1:0]   walk_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CHAR_W-1:0]   wr_data;
   logic [CHAR_W-1:0]   old_char;

   assign clearing  = (state_ff == S_CLEAR);
   assign out_free  = ~out_valid_ff | rsp_pop;
   assign walk_ok   = (32'(row_ff) < ROWS) && (32'(col_ff) < COLS);
   assign walk_addr = cell_addr(row_ff, col_ff);
   assign rd_addr   = (state_ff == S_WALK) ? walk_addr : cell_addr(q_cmd.row, q_cmd.col);
   assign old_char  = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   assign wr_en   = clearing | b_valid_ff;
   assign wr_addr = clearing ? clr_addr_ff : b_addr_ff;
   assign wr_data = clearing ? CH_BLANK :
                    ((old_char == CH_BLANK) || (old_char == b_mark_ff)) ? b_mark_ff : CH_CROSS;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      row_move_in   = row_move_ff;
      row_dec_in    = row_dec_ff;
      col_move_in   = col_move_ff;
      mark_in       = mark_ff;
      rd_ok_in      = rd_ok_ff;
      b_valid_in    = 1'b0;
      b_addr_in     = b_addr_ff;
      b_mark_in     = b_mark_ff;
      q_pop         = 1'b0;
      post          = 1'b0;
      out_status_in = out_status_ff;
      out_char_in   = out_char_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               if (q_cmd.is_read) begin
                  rd_ok_in = (32'(q_cmd.row) < ROWS) && (32'(q_cmd.col) < COLS);
                  state_in = S_RDATA;
               end else begin
                  // the draw status can go out now: later reads queue behind the walk
                  post          = 1'b1;
                  out_status_in = q_cmd.status;
                  out_char_in   = '0;
                  if (q_cmd.status != ST_BENT) begin
                     row_in      = q_cmd.row;
                     col_in      = q_cmd.col;
                     cnt_in      = q_cmd.len;
                     row_move_in = q_cmd.row_move;
                     row_dec_in  = q_cmd.row_dec;
                     col_move_in = q_cmd.col_move;
                     mark_in     = mark_of(q_cmd.status);
                     state_in    = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            b_valid_in = walk_ok;
            b_addr_in  = walk_addr;
            b_mark_in  = mark_ff;
            if (row_move_ff) begin
               row_in = row_dec_ff ? row_ff - 1'b1 : row_ff + 1'b1;
            end
            if (col_move_ff) begin
               col_in = col_ff + 1'b1;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         S_RDATA: begin
            post          = 1'b1;
            out_status_in = ST_READ;
            out_char_in   = rd_ok_ff ? old_char : '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (post) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         fwd_hit_ff   <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      cnt_ff        <= cnt_in;
      row_move_ff   <= row_move_in;
      row_dec_ff    <= row_dec_in;
      col_move_ff   <= col_move_in;
      mark_ff       <= mark_in;
      rd_ok_ff      <= rd_ok_in;
      b_addr_ff     <= b_addr_in;
      b_mark_ff     <= b_mark_in;
      fwd_data_ff   <= wr_data;
      out_status_ff <= out_status_in;
      out_char_ff   <= out_char_in;
   end

   // raster memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         raster_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= raster_mem[rd_addr];
   end

   assign rsp_empty     = ~out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_cell_char = out_char_ff;

`ifndef ASSERT_OFF
   a_post_into_free: assert property (@(posedge clock) disable iff (reset)
      post |-> out_free)
      else $error("result posted over a waiting result");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE) && !q_empty)
      else $error("command taken outside idle");

   a_no_rmw_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !b_valid_ff)
      else $error("cell update during clearing pass");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) && (cnt_ff == '0) |=> (state_ff == S_IDLE))
      else $error("walk did not end after last cell");
`endif

endmodule

[sv/char_raster_line_drawer_core.sv]
// A draw request's status passes through the command queue entry and the output register
// before it can be popped; a read's cell also passes the S_RDATA state and the registered
// raster read. A straight draw occupies the cell walker until its last cell is written, and
// a bent line posts its status without a walk. The walker does one read-modify-write per cell on the raster memory.
// Reset (synchronous, active high) starts a clearing pass that writes '*' to all
// ROWS*COLS cells, with req_full held high until it ends.
module char_raster_line_drawer_core (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_op,
   input  logic [crld_pkg::COORD_W-1:0]  req_start_row,
   input  logic [crld_pkg::COORD_W-1:0]  req_start_col,
   input  logic [crld_pkg::COORD_W-1:0]  req_end_row,
   input  logic [crld_pkg::COORD_W-1:0]  req_end_col,
   // response side
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [2:0]                    rsp_status,
   output logic [crld_pkg::CHAR_W-1:0]   rsp_cell_char
);
   import crld_pkg::*;

   // classified requests between the front and the cell walker
   cmd_type  push_cmd;
   cmd_type  pop_cmd;
   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;
   logic     clearing;

   // Front: take a request when the queue has room and the raster is not
   // being cleared, and classify the line in one pass.
   crld_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_start_row (req_start_row),
      .req_start_col (req_start_col),
      .req_end_row   (req_end_row),
      .req_end_col   (req_end_col),
      .q_full        (q_full),
      .clearing      (clearing),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   // Short queue: hold classified requests so the front keeps accepting
   // while the walker is busy on a long line.
   crld_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // Back: walk the line one cell per cycle through the raster memory,
   // forwarding the cell just written, and hold the result in an output
   // register until it is popped.
   crld_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_cmd         (pop_cmd),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_status    (rsp_status),
      .rsp_cell_char (rsp_cell_char)
   );

endmodule
